### design/btdm_pkg.sv
package btdm_pkg;

  localparam int unsigned TABLE_DEPTH = 32;

  localparam int unsigned BSSID_W = 48;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned RSSI_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WIN_W   = 16;
  localparam int unsigned SEL_W   = 5;

  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [7:0] FT_BEACON = 8'h80;
  localparam logic [7:0] FT_DEAUTH = 8'hC0;

  localparam logic [2:0] KIND_IGNORED  = 3'd0;
  localparam logic [2:0] KIND_HIT      = 3'd1;
  localparam logic [2:0] KIND_INSERTED = 3'd2;
  localparam logic [2:0] KIND_FULL     = 3'd3;
  localparam logic [2:0] KIND_DEAUTH   = 3'd4;
  localparam logic [2:0] KIND_CLEARED  = 3'd5;
  localparam logic [2:0] KIND_READ     = 3'd6;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd5000;

  typedef struct packed {
    logic [1:0]               action;
    logic                     is_management;
    logic [7:0]               frame_type;
    logic [BSSID_W-1:0]       bssid;
    logic [CHAN_W-1:0]        channel;
    logic signed [RSSI_W-1:0] rssi;
    logic [TIME_W-1:0]        now_ms;
    logic [SEL_W-1:0]         entry_select;
  } btdm_in_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic [4:0]               entry_index;
    logic [5:0]               entry_count;
    logic [TIME_W-1:0]        deauth_total;
    logic                     alert;
    logic                     read_valid;
    logic [BSSID_W-1:0]       read_bssid;
    logic [CHAN_W-1:0]        read_channel;
    logic signed [RSSI_W-1:0] read_rssi;
  } btdm_out_t;

  typedef struct packed {
    logic                     en;
    logic                     beacon;
    logic                     clear;
    logic                     read;
    logic                     any_hit;
    logic [BSSID_W-1:0]       bssid;
    logic [CHAN_W-1:0]        channel;
    logic signed [RSSI_W-1:0] rssi;
  } btdm_cmd_t;

  typedef struct packed {
    logic                     hit;
    logic                     ins;
    logic                     rd;
    logic [BSSID_W-1:0]       bssid;
    logic [CHAN_W-1:0]        channel;
    logic signed [RSSI_W-1:0] rssi;
  } btdm_resp_t;

endpackage

### design/beacon_table_deauth_monitor.sv
// Channel  | Ports                          | Moves
// ---------+--------------------------------+-------------------------------------
// input    | in_valid, in_ready, in_data    | one frame, clear or read transaction
// result   | out_valid, out_ready, out_data | one result per input transaction
// config   | cfg_we, cfg_wdata              | alert window in ms, no wait
//
// An item is taken into the item register; then, in the execute step, every table cell
// compares the BSSID at once and the row of cells updates. No new item is taken until
// the execute step is done. The result register lets the next item in while a result
// waits; a stalled result holds the execute step. Reset (rst_n low at a clock edge)
// empties the table and zeroes the counters and time stamp; no clearing pass is needed.
module beacon_table_deauth_monitor (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  btdm_pkg::btdm_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output btdm_pkg::btdm_out_t  out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import btdm_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic                     busy_r, busy_nxt;
  btdm_in_t                 item_r;
  logic                     out_valid_r, out_valid_nxt;
  btdm_out_t                out_data_r, out_data_nxt;
  logic [WIN_W-1:0]         window_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [TIME_W-1:0]        deauth_cnt_r, deauth_cnt_nxt;
  logic [TIME_W-1:0]        last_time_r, last_time_nxt;

  logic                     in_fire, fire;
  logic                     is_beacon, is_deauth, full, any_hit, any_ins;
  logic [IDX_W-1:0]         idx;
  logic                     rd_any;
  logic [BSSID_W-1:0]       rd_bssid;
  logic [CHAN_W-1:0]        rd_chan;
  logic signed [RSSI_W-1:0] rd_rssi;
  logic [TIME_W-1:0]        age;

  btdm_cmd_t                cmd;
  btdm_resp_t               resp [TABLE_DEPTH];
  logic [TABLE_DEPTH:0]     vchain;
  logic [TABLE_DEPTH-1:0]   hit_vec;
  logic [TABLE_DEPTH-1:0]   sel_vec;

  assign in_ready  = ~busy_r;
  assign in_fire   = in_valid & in_ready;
  assign fire      = busy_r & (~out_valid_r | out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_beacon = (item_r.action == ACT_FRAME) & item_r.is_management &
                     (item_r.frame_type == FT_BEACON);
  assign is_deauth = (item_r.action == ACT_FRAME) & item_r.is_management &
                     (item_r.frame_type == FT_DEAUTH);
  assign full      = vchain[TABLE_DEPTH];

  assign cmd.en      = fire;
  assign cmd.beacon  = is_beacon;
  assign cmd.clear   = (item_r.action == ACT_CLEAR);
  assign cmd.read    = (item_r.action == ACT_READ);
  assign cmd.any_hit = any_hit;
  assign cmd.bssid   = item_r.bssid;
  assign cmd.channel = item_r.channel;
  assign cmd.rssi    = item_r.rssi;

  assign vchain[0] = 1'b1;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    assign sel_vec[g] = (32'(item_r.entry_select) == 32'(g));
    assign hit_vec[g] = resp[g].hit;
    btdm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_valid (vchain[g]),
      .selected   (sel_vec[g]),
      .valid      (vchain[g+1]),
      .resp       (resp[g])
    );
  end

  assign any_hit = |hit_vec;

  always_comb begin
    any_ins  = 1'b0;
    idx      = '0;
    rd_any   = 1'b0;
    rd_bssid = '0;
    rd_chan  = '0;
    rd_rssi  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      any_ins  = any_ins | resp[i].ins;
      if (resp[i].hit | resp[i].ins) begin
        idx = idx | IDX_W'(i);
      end
      rd_any   = rd_any | resp[i].rd;
      rd_bssid = rd_bssid | resp[i].bssid;
      rd_chan  = rd_chan | resp[i].channel;
      rd_rssi  = rd_rssi | resp[i].rssi;
    end
  end

  always_comb begin
    count_nxt      = count_r;
    deauth_cnt_nxt = deauth_cnt_r;
    last_time_nxt  = last_time_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (any_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (is_deauth) begin
      deauth_cnt_nxt = deauth_cnt_r + TIME_W'(1);
      last_time_nxt  = item_r.now_ms;
    end
    age = item_r.now_ms - last_time_nxt;

    out_data_nxt              = out_data_r;
    out_data_nxt.kind         = KIND_IGNORED;
    out_data_nxt.entry_index  = 5'(idx);
    out_data_nxt.entry_count  = 6'(count_nxt);
    out_data_nxt.deauth_total = deauth_cnt_nxt;
    out_data_nxt.alert        = (age < TIME_W'(window_r));
    out_data_nxt.read_valid   = rd_any;
    out_data_nxt.read_bssid   = rd_bssid;
    out_data_nxt.read_channel = rd_chan;
    out_data_nxt.read_rssi    = rd_rssi;
    case (item_r.action)
      ACT_FRAME: begin
        if (is_beacon) begin
          if (any_hit) begin
            out_data_nxt.kind = KIND_HIT;
          end else if (full) begin
            out_data_nxt.kind = KIND_FULL;
          end else begin
            out_data_nxt.kind = KIND_INSERTED;
          end
        end else if (is_deauth) begin
          out_data_nxt.kind = KIND_DEAUTH;
        end
      end
      ACT_CLEAR: out_data_nxt.kind = KIND_CLEARED;
      ACT_READ:  out_data_nxt.kind = KIND_READ;
      default:   out_data_nxt.kind = KIND_IGNORED;
    endcase

    busy_nxt      = (busy_r & ~fire) | in_fire;
    out_valid_nxt = fire | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      window_r     <= WINDOW_RESET;
      count_r      <= '0;
      deauth_cnt_r <= '0;
      last_time_r  <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      if (fire) begin
        count_r      <= count_nxt;
        deauth_cnt_r <= deauth_cnt_nxt;
        last_time_r  <= last_time_nxt;
      end
    end
    if (in_fire) begin
      item_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_chain_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'($countones(vchain[TABLE_DEPTH:1])) == 32'(count_r))
    else $error("cell valid chain disagrees with entry count");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot0(hit_vec))
    else $error("more than one cell matched the BSSID");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && !busy_r)
    else $error("execute step did not produce a result");

endmodule

### design/btdm_cell.sv
module btdm_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  btdm_pkg::btdm_cmd_t   cmd,
  input  logic                  left_valid,
  input  logic                  selected,
  output logic                  valid,
  output btdm_pkg::btdm_resp_t  resp
);
  import btdm_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [BSSID_W-1:0]       bssid_r, bssid_nxt;
  logic [CHAN_W-1:0]        chan_r, chan_nxt;
  logic signed [RSSI_W-1:0] rssi_r, rssi_nxt;
  logic                     hit, ins, rd;

  assign hit = cmd.beacon & valid_r & (bssid_r == cmd.bssid);
  assign ins = cmd.beacon & ~cmd.any_hit & ~valid_r & left_valid;
  assign rd  = cmd.read & valid_r & selected;

  always_comb begin
    valid_nxt = valid_r;
    bssid_nxt = bssid_r;
    chan_nxt  = chan_r;
    rssi_nxt  = rssi_r;
    if (cmd.en) begin
      if (cmd.clear) begin
        valid_nxt = 1'b0;
      end else if (ins) begin
        valid_nxt = 1'b1;
        bssid_nxt = cmd.bssid;
      end
      if (hit | ins) begin
        chan_nxt = cmd.channel;
        rssi_nxt = cmd.rssi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    bssid_r <= bssid_nxt;
    chan_r  <= chan_nxt;
    rssi_r  <= rssi_nxt;
  end

  assign valid        = valid_r;
  assign resp.hit     = hit;
  assign resp.ins     = ins;
  assign resp.rd      = rd;
  assign resp.bssid   = rd ? bssid_r : '0;
  assign resp.channel = rd ? chan_r : '0;
  assign resp.rssi    = rd ? rssi_r : '0;

endmodule
